// ----- rtl/bqim_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the block-quantised int8 matrix-vector row engine.
// Used by bqim_ctrl, bqim_dp and block_quantized_int8_matvec; depends on nothing.

package bqim_pkg;

    localparam int ROW_LENGTH_MAX_DEF = 4096;
    localparam int COLUMN_LIMIT_DEF   = 65536;

    localparam int IDX_W   = 12;
    localparam int ACT_W   = 16;
    localparam int WGT_W   = 8;
    localparam int SCALE_W = 16;
    localparam int WS_W    = WGT_W + SCALE_W;
    localparam int PROD_W  = ACT_W + WS_W;
    localparam int SUM_W   = 56;
    localparam int COL_W   = 16;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_WEIGHT = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                      cmd;
        logic [IDX_W-1:0]          element_index;
        logic signed [ACT_W-1:0]   activation_value;
        logic signed [WGT_W-1:0]   weight_value;
        logic signed [SCALE_W-1:0] block_scale;
        logic                      last_in_column;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] dot_value;
        logic [COL_W-1:0]        column_index;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_ACC  = 2'd2
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_load;
        logic take_weight;
        logic do_mul;
        logic do_acc;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic acc_last;
        logic out_busy;
    } t_dp_status;

endpackage

// ----- rtl/bqim_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the row engine: accepts words and sequences the datapath.
// Depends on bqim_pkg.

module bqim_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_cmd,
    output logic                  o_in_ready,
    input  bqim_pkg::t_dp_status  i_status,
    output bqim_pkg::t_dp_cmd     o_cmd
);

    bqim_pkg::t_state r_state;
    bqim_pkg::t_state n_state;
    logic             acc_block;
    logic             fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bqim_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        // A final weight cannot complete while the previous result is still unread.
        acc_block  = (r_state == bqim_pkg::ST_ACC) && i_status.acc_last && i_status.out_busy;
        // No word is taken while reset is held.
        o_in_ready = i_rst_n && ((r_state == bqim_pkg::ST_IDLE) ||
                                 ((r_state == bqim_pkg::ST_ACC) && !acc_block));
        fire       = i_in_valid && o_in_ready;

        o_cmd.take_load   = fire && (i_in_cmd == bqim_pkg::CMD_LOAD);
        o_cmd.take_weight = fire && (i_in_cmd == bqim_pkg::CMD_WEIGHT);
        o_cmd.do_mul      = (r_state == bqim_pkg::ST_MUL);
        o_cmd.do_acc      = (r_state == bqim_pkg::ST_ACC) && !acc_block;

        n_state = r_state;
        case (r_state)
            bqim_pkg::ST_IDLE: begin
                if (o_cmd.take_weight) begin
                    n_state = bqim_pkg::ST_MUL;
                end
            end
            bqim_pkg::ST_MUL: begin
                n_state = bqim_pkg::ST_ACC;
            end
            bqim_pkg::ST_ACC: begin
                if (acc_block) begin
                    n_state = bqim_pkg::ST_ACC;
                end else if (o_cmd.take_weight) begin
                    n_state = bqim_pkg::ST_MUL;
                end else begin
                    n_state = bqim_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bqim_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_mul_then_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bqim_pkg::ST_MUL) |=> (r_state == bqim_pkg::ST_ACC))
        else $error("multiply stage not followed by accumulate stage");

    a_weight_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_weight |=> (r_state == bqim_pkg::ST_MUL))
        else $error("accepted weight word did not start the multiply stage");
`endif

endmodule

// ----- rtl/bqim_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the row engine: activation row store, weight-scale and activation multipliers,
// saturating accumulator, column counter and output register. Depends on bqim_pkg.

module bqim_dp #(
    parameter int ROW_LENGTH_MAX = bqim_pkg::ROW_LENGTH_MAX_DEF,
    parameter int COLUMN_LIMIT   = bqim_pkg::COLUMN_LIMIT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bqim_pkg::t_dp_cmd     i_cmd,
    input  bqim_pkg::t_in_item    i_item,
    output bqim_pkg::t_dp_status  o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output bqim_pkg::t_out_item   o_out
);

    localparam int ADDR_W = (ROW_LENGTH_MAX > 1) ? $clog2(ROW_LENGTH_MAX) : 1;

    logic signed [bqim_pkg::ACT_W-1:0]  mem [ROW_LENGTH_MAX];

    logic [31:0]                        idx_ext;
    logic [ADDR_W-1:0]                  addr;
    logic                               in_range;

    logic signed [bqim_pkg::ACT_W-1:0]  r_act;
    logic                               r_in_range;
    logic signed [bqim_pkg::WS_W-1:0]   r_ws;
    logic                               r_last;
    logic signed [bqim_pkg::ACT_W-1:0]  act_eff;
    logic signed [bqim_pkg::PROD_W-1:0] r_prod;
    logic                               r_last_p;

    logic signed [bqim_pkg::SUM_W-1:0]  r_sum;
    logic signed [bqim_pkg::SUM_W:0]    sum_wide;
    logic signed [bqim_pkg::SUM_W-1:0]  sum_sat;
    logic [bqim_pkg::COL_W-1:0]         r_col;
    logic [bqim_pkg::COL_W:0]           col_inc;
    logic [bqim_pkg::COL_W-1:0]         col_next;
    logic                               emit;

    logic                               r_out_valid;
    bqim_pkg::t_out_item                r_out;

    assign idx_ext  = 32'(i_item.element_index);
    assign addr     = idx_ext[ADDR_W-1:0];
    assign in_range = idx_ext < 32'(ROW_LENGTH_MAX);

    // Row store: single port, written by load words and read by weight words.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_load && in_range) begin
            mem[addr] <= i_item.activation_value;
        end
        if (i_cmd.take_weight) begin
            r_act <= mem[addr];
        end
    end

    // Weight times block scale is formed as the word is taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_weight) begin
            r_in_range <= in_range;
            r_ws       <= $signed(i_item.weight_value) * $signed(i_item.block_scale);
            r_last     <= i_item.last_in_column;
        end
    end

    assign act_eff = r_in_range ? r_act : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_mul) begin
            r_prod   <= act_eff * r_ws;
            r_last_p <= r_last;
        end
    end

    always_comb begin
        sum_wide = (bqim_pkg::SUM_W+1)'(r_sum) + (bqim_pkg::SUM_W+1)'(r_prod);
        if (sum_wide[bqim_pkg::SUM_W] != sum_wide[bqim_pkg::SUM_W-1]) begin
            sum_sat = sum_wide[bqim_pkg::SUM_W] ? bqim_pkg::SUM_MIN : bqim_pkg::SUM_MAX;
        end else begin
            sum_sat = sum_wide[bqim_pkg::SUM_W-1:0];
        end
        col_inc  = {1'b0, r_col} + 1'b1;
        col_next = (col_inc >= (bqim_pkg::COL_W+1)'(COLUMN_LIMIT)) ? '0
                                                                  : col_inc[bqim_pkg::COL_W-1:0];
        emit     = i_cmd.do_acc && r_last_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.do_acc) begin
                r_sum <= r_last_p ? '0 : sum_sat;
            end
            // A load word arriving with a final weight still clears the column count.
            if (i_cmd.take_load) begin
                r_col <= '0;
            end else if (emit) begin
                r_col <= col_next;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.dot_value    <= sum_sat;
            r_out.column_index <= r_col;
        end
    end

    assign o_status.acc_last = r_last_p;
    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(emit && r_out_valid && !i_out_ready))
        else $error("result word overwritten before it was taken");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_sum == '0))
        else $error("running sum not cleared after a result");

    a_load_clears_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_load |=> (r_col == '0))
        else $error("column count not cleared by a load word");
`endif

endmodule

// ----- rtl/block_quantized_int8_matvec.sv -----
`timescale 1ns / 1ps
// Block-quantised int8 matrix-vector row engine: top level joining controller and datapath.
// Depends on bqim_pkg, bqim_ctrl and bqim_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) carries one word per item. A load word
//   (cmd 0) writes one Q8.8 activation into the row store and clears the column count.
//   A weight word (cmd 1) adds activation[index] * weight * scale to the running sum.
//   Output channel (o_out_valid / i_out_ready / o_out) carries one Q32.24 result word with
//   its column number for each weight word marked last.
// Sequence: a load word is stored as it is taken. A weight word passes through the
//   weight-scale product and registered row-store read as it is taken, the activation
//   multiply, and the accumulate step, which overlaps the taking of the next word.
// Result path: a final weight word's result is written to the output register in its
//   accumulate step, after the weight-scale product and activation product registers.
// Reset: the running sum and column count clear, the output is emptied and the input is
//   not ready while reset is held. The row store has no reset; every entry must be loaded
//   before a weight word reads it.
// Stall: the single output register holds its word until taken. A further final weight
//   waits in its accumulate step, and the input is not ready until that result can be
//   written.

module block_quantized_int8_matvec #(
    parameter int ROW_LENGTH_MAX = bqim_pkg::ROW_LENGTH_MAX_DEF,
    parameter int COLUMN_LIMIT   = bqim_pkg::COLUMN_LIMIT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bqim_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bqim_pkg::t_out_item  o_out
);

    bqim_pkg::t_dp_cmd    dp_cmd;
    bqim_pkg::t_dp_status dp_status;

    bqim_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    bqim_dp #(
        .ROW_LENGTH_MAX (ROW_LENGTH_MAX),
        .COLUMN_LIMIT   (COLUMN_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_item      (i_in),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
